// ===== src/mdas_pkg.sv =====
// ----------------------------------------------------------------------------
// mdas_pkg: shared types and constants of the multidimensional array store
// Field widths, status and opcode codes, register indexes and the lane
// control group.
// ----------------------------------------------------------------------------
package mdas_pkg;

    localparam int INDEX_PORTS   = 4;
    localparam int IDX_BITS      = 12;
    localparam int BOUND_BITS    = 13;
    localparam int VALUE_BITS    = 32;
    localparam int NUM_DIMS_BITS = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;
    localparam int WIDE_BITS     = 64;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_STORE = 2'd2
    } t_status;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NUM_DIMS = 3'd0,
        CFG_BOUND_0  = 3'd1,
        CFG_BOUND_1  = 3'd2,
        CFG_BOUND_2  = 3'd3,
        CFG_BOUND_3  = 3'd4
    } t_cfg_reg;

    // Control strobes that the sequencer hands to every lane.
    typedef struct packed {
        logic load;         // capture index and range check on a transfer
        logic stride_load;  // capture the broadcast stride
        logic mul;          // form index times stride
    } t_lane_ctl;

endpackage

// ===== src/mdas_if.sv =====
// ----------------------------------------------------------------------------
// mdas_req_if / mdas_rsp_if: access and result channels
// Valid/ready channels carrying one access and one result.
// ----------------------------------------------------------------------------
interface mdas_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [11:0] index_0;
    logic [11:0] index_1;
    logic [11:0] index_2;
    logic [11:0] index_3;
    logic [31:0] write_value;

    modport source (output valid, output opcode, output index_0, output index_1,
                    output index_2, output index_3, output write_value, input ready);
    modport sink   (input valid, input opcode, input index_0, input index_1,
                    input index_2, input index_3, input write_value, output ready);
endinterface

interface mdas_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [1:0]  status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

// ===== src/mdas_lane.sv =====
// ----------------------------------------------------------------------------
// mdas_lane: one dimension lane
// Checks its index against its bound and forms index times stride.
// ----------------------------------------------------------------------------
module mdas_lane #(
    parameter int STRIDE_BITS = 13
) (
    input  logic                                   i_clk,
    input  mdas_pkg::t_lane_ctl                    i_ctl,
    input  logic                                   i_active,
    input  logic [mdas_pkg::IDX_BITS-1:0]          i_index,
    input  logic [mdas_pkg::BOUND_BITS-1:0]        i_bound,
    input  logic [STRIDE_BITS-1:0]                 i_stride,
    output logic                                   o_in_range,
    output logic [mdas_pkg::IDX_BITS+STRIDE_BITS-1:0] o_product
);
    import mdas_pkg::*;

    localparam int PW = IDX_BITS + STRIDE_BITS;

    logic [IDX_BITS-1:0]    r_index;
    logic                   r_active;
    logic                   r_in_range;
    logic [STRIDE_BITS-1:0] r_stride;
    logic [PW-1:0]          r_product;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_index    <= i_index;
            r_active   <= i_active;
            // An unused dimension never fails the check.
            r_in_range <= !i_active || (BOUND_BITS'(i_index) < i_bound);
        end
        if (i_ctl.stride_load) begin
            r_stride <= i_stride;
        end
        if (i_ctl.mul) begin
            r_product <= r_active ? PW'(r_index) * PW'(r_stride) : '0;
        end
    end

    assign o_in_range = r_in_range;
    assign o_product  = r_product;

endmodule

// ===== src/mdas_merge.sv =====
// ----------------------------------------------------------------------------
// mdas_merge: lane merge
// Sums the lane products into the element offset and decides the status.
// ----------------------------------------------------------------------------
module mdas_merge #(
    parameter int LANES       = 4,
    parameter int STORE_DEPTH = 4096,
    parameter int STRIDE_BITS = 13,
    parameter int ADDR_BITS   = 12
) (
    input  logic [LANES-1:0]                                    i_in_range,
    input  logic [mdas_pkg::IDX_BITS+STRIDE_BITS-1:0]           i_product [LANES],
    input  logic [STRIDE_BITS-1:0]                              i_total,
    output mdas_pkg::t_status                                   o_status,
    output logic [ADDR_BITS-1:0]                                o_addr
);
    import mdas_pkg::*;

    localparam int PW   = IDX_BITS + STRIDE_BITS;
    localparam int SUMW = PW + $clog2(LANES + 1);

    logic [SUMW-1:0] w_sum;

    always_comb begin
        w_sum = '0;
        for (int d = 0; d < LANES; d++) begin
            w_sum = w_sum + SUMW'(i_product[d]);
        end
    end

    always_comb begin
        priority if (i_total > STRIDE_BITS'(STORE_DEPTH)) begin
            o_status = ST_STORE;
        end else if (!(&i_in_range) || (w_sum >= SUMW'(STORE_DEPTH))) begin
            o_status = ST_RANGE;
        end else begin
            o_status = ST_OK;
        end
    end

    assign o_addr = w_sum[ADDR_BITS-1:0];

endmodule

// ===== src/mdas_store.sv =====
// ----------------------------------------------------------------------------
// mdas_store: element memory
// Single-port element store with registered read data.
// ----------------------------------------------------------------------------
module mdas_store #(
    parameter int DEPTH     = 4096,
    parameter int ELEM_BITS = 32,
    parameter int ADDR_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [ELEM_BITS-1:0] i_wdata,
    output logic [ELEM_BITS-1:0] o_rdata
);
    logic [ELEM_BITS-1:0] r_mem [DEPTH];
    logic [ELEM_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/multidim_array_store.sv =====
// ----------------------------------------------------------------------------
// multidim_array_store: row-major multidimensional element store
// Holds one array of up to four dimensions and serves one read or write per
// access, with bound checking and a check of the array size against memory.
// ----------------------------------------------------------------------------
// An access is taken on the request channel, one at a time, and answered by
// exactly one transfer on the result channel. An access runs through the
// states S_STRIDE, S_MUL, S_SUM, S_MEM and S_DONE before its result is held
// in the output register, and the next access is taken only once that result
// is there. In S_STRIDE the strides are built from the bounds with one
// saturating multiply per dimension; then the lanes form index times stride,
// the merge sums them, and the memory port is used in S_MEM with its read
// data registered. A waiting result never blocks the next transfer in;
// only the final hand-over into the output register waits for it to drain.
// Configuration is written through the plain write port; the user must do
// so only while the block is idle, which the block does not enforce. The
// memory needs no clearing after reset if an element is only read after it
// has been written; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module multidim_array_store #(
    parameter int MAX_DIMS    = 4,
    parameter int STORE_DEPTH = 4096,
    parameter int ELEM_BITS   = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    mdas_req_if.sink                              i_req,
    mdas_rsp_if.source                            o_rsp,
    input  logic                                  i_cfg_we,
    input  logic [mdas_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [mdas_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import mdas_pkg::*;

    // Dimensions the block can use, limited by the number of index fields.
    localparam int DIM_LIMIT = (MAX_DIMS < INDEX_PORTS) ? MAX_DIMS : INDEX_PORTS;
    localparam int SIDX      = (DIM_LIMIT > 1) ? $clog2(DIM_LIMIT) : 1;
    // Strides and the element count saturate at STORE_DEPTH + 1.
    localparam int SW        = $clog2(STORE_DEPTH + 2);
    localparam int AW        = $clog2(STORE_DEPTH);
    localparam int PW        = IDX_BITS + SW;
    localparam int MW        = SW + BOUND_BITS;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_STRIDE = 6'b000010,
        S_MUL    = 6'b000100,
        S_SUM    = 6'b001000,
        S_MEM    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [NUM_DIMS_BITS-1:0] r_num_dims;
    logic [BOUND_BITS-1:0]    r_bound [DIM_LIMIT];

    // Sequencer and per-access registers.
    logic [SIDX-1:0]          r_step;
    logic [SW-1:0]            r_acc;
    logic                     r_op;
    logic [ELEM_BITS-1:0]     r_wdata;
    t_status                  r_status;
    logic [AW-1:0]            r_addr;

    // Output register.
    logic                     r_out_valid;
    logic [VALUE_BITS-1:0]    r_out_value;
    t_status                  r_out_status;

    logic                     w_accept;
    logic                     w_out_free;
    logic [SIDX-1:0]          w_last;
    logic [IDX_BITS-1:0]      w_index [INDEX_PORTS];
    logic [MW-1:0]            w_acc_prod;
    logic [SW-1:0]            n_acc;
    logic [DIM_LIMIT-1:0]     w_in_range;
    logic [PW-1:0]            w_product [DIM_LIMIT];
    t_status                  w_status;
    logic [AW-1:0]            w_addr;
    logic                     w_mem_we;
    logic                     w_mem_re;
    logic [ELEM_BITS-1:0]     w_rdata;
    logic [WIDE_BITS-1:0]     w_wide_wdata;
    logic [WIDE_BITS-1:0]     w_wide_rdata;

    assign w_index[0] = i_req.index_0;
    assign w_index[1] = i_req.index_1;
    assign w_index[2] = i_req.index_2;
    assign w_index[3] = i_req.index_3;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    // Last dimension in use: a count of zero acts as one, and counts above
    // the lane count are clamped to it.
    always_comb begin
        priority if (r_num_dims == '0) begin
            w_last = '0;
        end else if (r_num_dims > NUM_DIMS_BITS'(DIM_LIMIT)) begin
            w_last = SIDX'(DIM_LIMIT - 1);
        end else begin
            w_last = SIDX'(r_num_dims - 1'b1);
        end
    end

    // Configuration writes; indexes past the last bound register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NUM_DIMS_BITS'(1);
            for (int d = 0; d < DIM_LIMIT; d++) begin
                r_bound[d] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_NUM_DIMS) begin
                r_num_dims <= i_cfg_data[NUM_DIMS_BITS-1:0];
            end
            for (int d = 0; d < DIM_LIMIT; d++) begin
                if (i_cfg_index == CFG_BOUND_0 + CFG_IDX_BITS'(d)) begin
                    r_bound[d] <= i_cfg_data[BOUND_BITS-1:0];
                end
            end
        end
    end

    // Stride chain: walking from the innermost dimension outward, each lane
    // takes the running product as its stride before the product absorbs the
    // lane's own bound. What is left at the end is the element count.
    assign w_acc_prod = MW'(r_acc) * MW'(r_bound[r_step]);
    assign n_acc      = (w_acc_prod > MW'(STORE_DEPTH)) ? SW'(STORE_DEPTH + 1)
                                                        : w_acc_prod[SW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_STRIDE;
            S_STRIDE: if (r_step == '0) n_state = S_MUL;
            S_MUL:    n_state = S_SUM;
            S_SUM:    n_state = S_MEM;
            S_MEM:    n_state = S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-access payload registers.
    assign w_wide_wdata = WIDE_BITS'(i_req.write_value);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_step  <= w_last;
            r_acc   <= SW'(1);
            r_op    <= i_req.opcode;
            r_wdata <= w_wide_wdata[ELEM_BITS-1:0];
        end
        if (r_state == S_STRIDE) begin
            r_acc <= n_acc;
            if (r_step != '0) begin
                r_step <= r_step - 1'b1;
            end
        end
        if (r_state == S_SUM) begin
            r_status <= w_status;
            r_addr   <= w_addr;
        end
    end

    // One lane per dimension.
    for (genvar d = 0; d < DIM_LIMIT; d++) begin : g_lane
        t_lane_ctl w_ctl;

        assign w_ctl.load        = w_accept;
        assign w_ctl.stride_load = (r_state == S_STRIDE) && (r_step == SIDX'(d));
        assign w_ctl.mul         = (r_state == S_MUL);

        mdas_lane #(
            .STRIDE_BITS (SW)
        ) u_lane (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_active   (SIDX'(d) <= w_last),
            .i_index    (w_index[d]),
            .i_bound    (r_bound[d]),
            .i_stride   (r_acc),
            .o_in_range (w_in_range[d]),
            .o_product  (w_product[d])
        );
    end

    mdas_merge #(
        .LANES       (DIM_LIMIT),
        .STORE_DEPTH (STORE_DEPTH),
        .STRIDE_BITS (SW),
        .ADDR_BITS   (AW)
    ) u_merge (
        .i_in_range (w_in_range),
        .i_product  (w_product),
        .i_total    (r_acc),
        .o_status   (w_status),
        .o_addr     (w_addr)
    );

    // The memory is touched only by an access that passed every check.
    assign w_mem_we = (r_state == S_MEM) && (r_status == ST_OK) && (r_op == OP_WRITE);
    assign w_mem_re = (r_state == S_MEM) && (r_status == ST_OK) && (r_op == OP_READ);

    mdas_store #(
        .DEPTH     (STORE_DEPTH),
        .ELEM_BITS (ELEM_BITS),
        .ADDR_BITS (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (r_addr),
        .i_wdata (r_wdata),
        .o_rdata (w_rdata)
    );

    // Result: the element on a good read, zero on writes and on errors.
    assign w_wide_rdata = WIDE_BITS'(w_rdata);

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_status <= r_status;
            r_out_value  <= ((r_status == ST_OK) && (r_op == OP_READ))
                            ? w_wide_rdata[VALUE_BITS-1:0] : '0;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.status     = r_out_status;

endmodule

// ===== src/mdas_checker.sv =====
// ----------------------------------------------------------------------------
// mdas_checker: port checks for the multidimensional array store
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module mdas_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_req_valid,
    input logic                                i_req_ready,
    input logic                                i_rsp_valid,
    input logic                                i_rsp_ready,
    input logic [mdas_pkg::VALUE_BITS-1:0]     i_rsp_value,
    input logic [1:0]                          i_rsp_status
);
    import mdas_pkg::*;

    // A result held back by the sink stays offered.
    a_rsp_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_rsp_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> ($stable(i_rsp_value) && $stable(i_rsp_status)))
        else $error("result payload changed while stalled");

    // A failed access never returns element data.
    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != ST_OK)) |-> (i_rsp_value == '0))
        else $error("nonzero data on a failed access");

    // Accesses are taken one at a time: no transfer in right after another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("access taken while another is in flight");

endmodule

bind multidim_array_store mdas_checker u_mdas_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_value  (o_rsp.read_value),
    .i_rsp_status (o_rsp.status)
);

// ===== dv/mdas_access_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdas_access_checker: result checker for the multidimensional array store
// Follows the configuration writes and every accepted access, keeps its own
// copy of the array shape and of the element contents, and compares each
// result transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mdas_access_checker #(
    parameter int MAX_DIMS    = 4,
    parameter int STORE_DEPTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    mdas_req_if                                i_req,
    mdas_rsp_if                                i_rsp,
    input  logic                               i_cfg_we,
    input  logic [mdas_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [mdas_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                 o_mismatches,
    output int                                 o_outstanding
);
    import mdas_pkg::*;

    localparam int DIM_LIMIT    = (MAX_DIMS < INDEX_PORTS) ? MAX_DIMS : INDEX_PORTS;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_status               status;
        logic [VALUE_BITS-1:0] read_value;
    } t_outcome;

    logic [NUM_DIMS_BITS-1:0] dims_reg;
    logic [BOUND_BITS-1:0]    bound_reg [INDEX_PORTS];
    logic [VALUE_BITS-1:0]    element_copy [STORE_DEPTH];
    t_outcome                 pending_outcomes [$];
    int                       mismatches = 0;

    // Works out the result of one access and applies a write to the local copy.
    // The size check comes first, so an oversized array never reports a range error.
    function automatic t_outcome apply_access(
        input logic                                  op,
        input logic [INDEX_PORTS-1:0][IDX_BITS-1:0]  subs,
        input logic [VALUE_BITS-1:0]                 wval
    );
        int unsigned     dims;
        int              d;
        longint unsigned total;
        longint unsigned offset;
        bit              in_range;
        t_outcome        res;
        dims     = (dims_reg == 0) ? 1 : ((dims_reg > DIM_LIMIT) ? DIM_LIMIT : dims_reg);
        total    = 1;
        offset   = 0;
        in_range = 1'b1;
        for (d = 0; d < dims; d++) begin
            total = total * bound_reg[d];
            if (subs[d] >= bound_reg[d]) begin
                in_range = 1'b0;
            end
            offset = offset * bound_reg[d] + subs[d];
        end
        res.status     = ST_OK;
        res.read_value = '0;
        if (total > STORE_DEPTH) begin
            res.status = ST_STORE;
        end else if (!in_range || offset >= STORE_DEPTH) begin
            res.status = ST_RANGE;
        end else if (op == OP_WRITE) begin
            element_copy[offset] = wval;
        end else begin
            res.read_value = element_copy[offset];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            dims_reg = 3'd1;
            foreach (bound_reg[d]) begin
                bound_reg[d] = '0;
            end
            pending_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_DIMS: dims_reg     = i_cfg_data[NUM_DIMS_BITS-1:0];
                    CFG_BOUND_0:  bound_reg[0] = i_cfg_data;
                    CFG_BOUND_1:  bound_reg[1] = i_cfg_data;
                    CFG_BOUND_2:  bound_reg[2] = i_cfg_data;
                    CFG_BOUND_3:  bound_reg[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                pending_outcomes.push_back(apply_access(i_req.opcode,
                    {i_req.index_3, i_req.index_2, i_req.index_1, i_req.index_0},
                    i_req.write_value));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_outcomes.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("%0t: result transfer with nothing outstanding: status %0d read_value %h",
                                 $time, i_rsp.status, i_rsp.read_value);
                    end
                    mismatches++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (i_rsp.status !== want.status || i_rsp.read_value !== want.read_value) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("%0t: result mismatch: status exp %0d got %0d, read_value exp %h got %h",
                                     $time, want.status, i_rsp.status, want.read_value,
                                     i_rsp.read_value);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= pending_outcomes.size();
    end

endmodule

// ===== dv/tb_multidim_array_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multidim_array_store: testbench of the multidimensional array store
// Programs a series of array shapes and sends directed and random accesses
// through the request channel with random idle cycles on both sides. A
// checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_multidim_array_store;
    import mdas_pkg::*;

    localparam int MAX_DIMS      = 4;
    localparam int STORE_DEPTH   = 4096;
    localparam int ELEM_BITS     = 32;
    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 3;
    localparam int IDLE_MAX      = 18;
    localparam int ACCESS_TARGET = 1800;
    // Long enough to cover an access over four dimensions with margin.
    localparam int SETTLE_CYCLES = 16;
    localparam int TIME_LIMIT_NS = 2_000_000;
    localparam int INDEX_MAX     = (1 << IDX_BITS) - 1;
    localparam int BOUND_MAX     = 4096;
    // A register index past the end of the list; writes to it must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;

    // One entry per dimension: subscripts of an access or bounds of a shape.
    typedef int unsigned t_per_dim [INDEX_PORTS];

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       mismatches;
    int                       outstanding;

    // When a side is calm it never idles, which gives stretches at full rate.
    bit source_calm;
    bit sink_calm;

    // Shape currently programmed, as the stimulus needs it to aim accesses.
    int unsigned     shape_dims;
    int unsigned     shape_bound [INDEX_PORTS];
    longint unsigned shape_total;
    // Elements that hold a value; reads of any other element are never sent.
    bit              written [STORE_DEPTH];

    int n_accesses;
    int n_writes;
    int n_reads;
    int n_rejects;
    int n_shapes;

    mdas_req_if req ();
    mdas_rsp_if rsp ();

    multidim_array_store #(
        .MAX_DIMS    (MAX_DIMS),
        .STORE_DEPTH (STORE_DEPTH),
        .ELEM_BITS   (ELEM_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mdas_access_checker #(
        .MAX_DIMS    (MAX_DIMS),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_rsp         (rsp),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // The dimension count register saturates: zero means one, anything above
    // the number of index ports means all of them.
    function automatic int unsigned effective_dims(input int unsigned raw);
        if (raw == 0) begin
            return 1;
        end
        if (raw > MAX_DIMS) begin
            return MAX_DIMS;
        end
        return raw;
    endfunction

    // Row-major element offset of an access, or -1 when the block must reject it
    // because an index is out of range or the array does not fit the store.
    function automatic int element_offset(input t_per_dim subs);
        int              d;
        longint unsigned offset;
        bit              fits;
        offset = 0;
        fits   = 1'b1;
        for (d = 0; d < shape_dims; d++) begin
            if (subs[d] >= shape_bound[d]) begin
                fits = 1'b0;
            end
            offset = offset * shape_bound[d] + subs[d];
        end
        if (shape_total > STORE_DEPTH || !fits) begin
            return -1;
        end
        return int'(offset);
    endfunction

    // Splits an offset back into subscripts; unused dimensions get random noise.
    function automatic void subs_of_offset(input int offset, output t_per_dim subs);
        int d;
        int rest;
        rest = offset;
        for (d = INDEX_PORTS - 1; d >= 0; d--) begin
            if (d < shape_dims) begin
                subs[d] = rest % shape_bound[d];
                rest    = rest / shape_bound[d];
            end else begin
                subs[d] = $urandom_range(0, INDEX_MAX);
            end
        end
    endfunction

    function automatic void random_in_range(output t_per_dim subs);
        int d;
        for (d = 0; d < INDEX_PORTS; d++) begin
            if (d < shape_dims) begin
                subs[d] = $urandom_range(0, shape_bound[d] - 1);
            end else begin
                subs[d] = $urandom_range(0, INDEX_MAX);
            end
        end
    endfunction

    // Looks for a written element inside the current array, starting at a
    // random place and wrapping around. Returns 0 when there is none.
    function automatic bit find_stored(output t_per_dim subs);
        int start;
        int k;
        int offset;
        start = $urandom_range(0, int'(shape_total) - 1);
        for (k = 0; k < int'(shape_total); k++) begin
            offset = (start + k) % int'(shape_total);
            if (written[offset]) begin
                subs_of_offset(offset, subs);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // A calm side never waits; otherwise about a quarter of the draws give no wait at all.
    function automatic int unsigned idle_cycles(input bit calm);
        if (calm || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(1, IDLE_MAX);
    endfunction

    // Drives one access and returns at the edge where it transfers. Valid is
    // left high, so the next call can follow at once without a gap; any code
    // that stops sending lowers it through drain_results.
    task automatic send_access(input t_opcode op, input t_per_dim subs,
                               input logic [VALUE_BITS-1:0] value);
        int unsigned gap;
        gap = idle_cycles(source_calm);
        if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid       <= 1'b1;
        req.opcode      <= op;
        req.index_0     <= subs[0][IDX_BITS-1:0];
        req.index_1     <= subs[1][IDX_BITS-1:0];
        req.index_2     <= subs[2][IDX_BITS-1:0];
        req.index_3     <= subs[3][IDX_BITS-1:0];
        req.write_value <= value;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    // Keeps the record of written elements and turns a read of an empty
    // element into a write, then sends the access.
    task automatic issue_access(input t_opcode op, input t_per_dim subs,
                                input logic [VALUE_BITS-1:0] value);
        int offset;
        offset = element_offset(subs);
        if (offset < 0) begin
            n_rejects++;
        end else begin
            if (op == OP_READ && !written[offset]) begin
                op = OP_WRITE;
            end
            if (op == OP_WRITE) begin
                written[offset] = 1'b1;
                n_writes++;
            end else begin
                n_reads++;
            end
        end
        n_accesses++;
        send_access(op, subs, value);
    endtask

    task automatic directed_access(input t_opcode op, input int unsigned s0,
                                   input int unsigned s1, input int unsigned s2,
                                   input int unsigned s3, input logic [VALUE_BITS-1:0] value);
        t_per_dim subs;
        subs[0] = s0;
        subs[1] = s1;
        subs[2] = s2;
        subs[3] = s3;
        issue_access(op, subs, value);
    endtask

    // Stops sending and waits until every outstanding result has transferred,
    // so the block is idle and may be reconfigured.
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] addr, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        @(posedge i_clk);
    endtask

    // Programs all five registers once the block is idle and updates the
    // shape that the stimulus aims at.
    task automatic set_shape(input int unsigned raw_dims, input t_per_dim bounds);
        int d;
        drain_results();
        cfg_write(CFG_NUM_DIMS, raw_dims);
        cfg_write(CFG_BOUND_0, bounds[0]);
        cfg_write(CFG_BOUND_1, bounds[1]);
        cfg_write(CFG_BOUND_2, bounds[2]);
        cfg_write(CFG_BOUND_3, bounds[3]);
        cfg_we <= 1'b0;
        shape_dims  = effective_dims(raw_dims % 8);
        shape_total = 1;
        for (d = 0; d < INDEX_PORTS; d++) begin
            shape_bound[d] = bounds[d];
            if (d < shape_dims) begin
                shape_total = shape_total * bounds[d];
            end
        end
        n_shapes++;
    endtask

    // The receiver draws a stall before each result and then holds ready high
    // until that result has transferred.
    initial begin
        int unsigned stall;
        rsp.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_cycles(sink_calm);
            if (stall != 0) begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp.valid) @(posedge i_clk);
        end
    end

    initial begin
        t_per_dim        bounds;
        t_per_dim        subs;
        t_opcode         op;
        logic [31:0]     value;
        int unsigned     raw;
        int unsigned     dims_now;
        int unsigned     kind;
        int unsigned     roll;
        int unsigned     count;
        int unsigned     d;
        bit              usable;

        // Every input is known from time zero, and reset is held low at the start.
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_NUM_DIMS;
        cfg_data        <= '0;
        req.valid       <= 1'b0;
        req.opcode      <= OP_READ;
        req.index_0     <= '0;
        req.index_1     <= '0;
        req.index_2     <= '0;
        req.index_3     <= '0;
        req.write_value <= '0;
        source_calm      = 1'b0;
        sink_calm        = 1'b0;
        // Shape after reset: one dimension with a bound of zero.
        shape_dims       = 1;
        shape_total      = 0;
        foreach (shape_bound[i]) begin
            shape_bound[i] = 0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed part ----------------
        // Straight out of reset every bound is zero, so nothing is in range.
        directed_access(OP_READ, 0, 0, 0, 0, 32'h0);
        directed_access(OP_WRITE, INDEX_MAX, INDEX_MAX, INDEX_MAX, INDEX_MAX, 32'hFFFF_FFFF);

        // A dimension count of zero counts as one; that dimension spans the
        // whole store, so both index extremes are legal.
        bounds = '{BOUND_MAX, 4095, 0, 1};
        set_shape(0, bounds);
        directed_access(OP_WRITE, INDEX_MAX, 0, 0, 0, 32'hFFFF_FFFF);
        directed_access(OP_WRITE, 0, INDEX_MAX, INDEX_MAX, INDEX_MAX, 32'h0000_0000);
        directed_access(OP_READ, INDEX_MAX, 1, 2, 3, 32'h0);
        directed_access(OP_READ, 0, 0, 0, 0, 32'hFFFF_FFFF);
        directed_access(OP_WRITE, 0, 0, 0, 0, 32'hA5A5_5A5A);

        // A write past the end of the register list must leave the shape alone.
        drain_results();
        cfg_write(CFG_SPARE, 13'h1FFF);
        cfg_we <= 1'b0;
        directed_access(OP_READ, 0, INDEX_MAX, 0, INDEX_MAX, 32'h0);

        // Four dimensions of 16 need 65536 elements: the store is too small,
        // and that is reported even when the indices are out of range too.
        bounds = '{16, 16, 16, 16};
        set_shape(4, bounds);
        directed_access(OP_WRITE, 0, 0, 0, 0, 32'h1234_5678);
        directed_access(OP_READ, INDEX_MAX, INDEX_MAX, INDEX_MAX, INDEX_MAX, 32'h0);

        // A count above four saturates to four; 4 x 8 x 16 x 8 fills the store
        // exactly, so the last element sits at the top offset.
        bounds = '{4, 8, 16, 8};
        set_shape(7, bounds);
        directed_access(OP_WRITE, 3, 7, 15, 7, 32'h8000_0001);
        directed_access(OP_WRITE, 0, 0, 0, 0, 32'h7FFF_FFFE);
        directed_access(OP_READ, 3, 7, 15, 7, 32'h0);
        directed_access(OP_READ, 0, 0, 0, 0, 32'h0);
        directed_access(OP_READ, 0, 0, 16, 0, 32'h0);
        directed_access(OP_WRITE, 0, 0, 0, INDEX_MAX, 32'h5555_AAAA);

        // A zero bound in use rejects every access; the bound beyond the
        // dimensions in use plays no part.
        bounds = '{2, 0, 2, 4095};
        set_shape(3, bounds);
        directed_access(OP_READ, 0, 0, 0, INDEX_MAX, 32'h0);
        directed_access(OP_WRITE, 1, 0, 1, 0, 32'hCAFE_F00D);

        // Two dimensions with an outer bound of one; the unused subscripts
        // carry all ones and must be ignored.
        bounds = '{1, BOUND_MAX, 5, 5};
        set_shape(2, bounds);
        directed_access(OP_WRITE, 0, INDEX_MAX, INDEX_MAX, INDEX_MAX, 32'h0F0F_F0F0);
        directed_access(OP_READ, 0, INDEX_MAX, 0, 0, 32'h0);
        directed_access(OP_READ, 1, 0, 0, 0, 32'h0);

        // ---------------- random part ----------------
        // Each phase programs a new shape, then sends a burst of accesses.
        // Most shapes are small so that reads often find stored elements;
        // some overflow the store, some have a zero bound and some are large.
        while (n_accesses < ACCESS_TARGET) begin
            source_calm = ($urandom_range(0, 3) == 0);
            sink_calm   = ($urandom_range(0, 3) == 0);

            kind = $urandom_range(0, 9);
            raw  = $urandom_range(0, 7);
            for (d = 0; d < INDEX_PORTS; d++) begin
                bounds[d] = $urandom_range(0, BOUND_MAX);
            end
            dims_now = effective_dims(raw);
            if (kind == 0) begin
                // At least two bounds of 65 or more cannot fit in 4096 elements.
                raw      = $urandom_range(2, 7);
                dims_now = effective_dims(raw);
                for (d = 0; d < dims_now; d++) begin
                    bounds[d] = $urandom_range(65, BOUND_MAX);
                end
            end else if (kind == 1) begin
                for (d = 0; d < dims_now; d++) begin
                    bounds[d] = $urandom_range(1, 6);
                end
                bounds[$urandom_range(0, dims_now - 1)] = 0;
            end else if (kind == 2) begin
                raw       = $urandom_range(0, 1);
                bounds[0] = $urandom_range(1024, BOUND_MAX);
            end else begin
                for (d = 0; d < dims_now; d++) begin
                    bounds[d] = $urandom_range(1, (dims_now == 1) ? 64 :
                                                  (dims_now == 2) ? 12 : 6);
                end
            end
            set_shape(raw, bounds);

            usable = (shape_total > 0) && (shape_total <= STORE_DEPTH);
            count  = usable ? $urandom_range(40, 120) : $urandom_range(12, 30);
            repeat (count) begin
                op    = t_opcode'($urandom_range(0, 1));
                value = $urandom();
                roll  = $urandom_range(0, 99);
                if (!usable || roll < 10) begin
                    // Noise over the full subscript range.
                    for (d = 0; d < INDEX_PORTS; d++) begin
                        subs[d] = $urandom_range(0, INDEX_MAX);
                    end
                end else if (roll < 20) begin
                    // A near miss: one subscript in use at or past its bound, if the bound is within range.
                    random_in_range(subs);
                    d = $urandom_range(0, shape_dims - 1);
                    if (shape_bound[d] <= INDEX_MAX) begin
                        subs[d] = $urandom_range(shape_bound[d], INDEX_MAX);
                    end
                end else if (roll < 60) begin
                    // Read back a stored element, or store one if none is there yet.
                    if (find_stored(subs)) begin
                        op = OP_READ;
                    end else begin
                        random_in_range(subs);
                        op = OP_WRITE;
                    end
                end else begin
                    random_in_range(subs);
                    op = OP_WRITE;
                end
                issue_access(op, subs, value);
            end
        end

        // Let every result come back, then give the block time to show any
        // stray transfer before judging the run.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d accesses over %0d array shapes: %0d writes, %0d reads of stored",
                 n_accesses, n_shapes, n_writes, n_reads);
        $display("elements and %0d rejected for range or size, with random idling on both sides.",
                 n_rejects);
        if (mismatches == 0) begin
            $display("[multidim_array_store] OK");
        end else begin
            $display("%0d results did not match.", mismatches);
            $display("[multidim_array_store] ERROR");
        end
        $finish;
    end

    // Hard limit on the run in case the block stops answering.
    initial begin
        #(TIME_LIMIT_NS);
        $display("Run stopped at its time limit with %0d results outstanding.", outstanding);
        $display("[multidim_array_store] ERROR");
        $finish;
    end

endmodule
